/* hw/rtl/apss_pkg.sv */
// Shared constants of the audio PLL setting search.
package apss_pkg;

    // Width of the magnitude that the shared divider handles.
    localparam int unsigned DIVIDEND_W = 56;
    // Width of the divisor (crystal frequency or scaled output divisor).
    localparam int unsigned DIVISOR_W  = 27;

    localparam int unsigned FREQ_W     = 27;
    localparam int unsigned ACH_W      = 26;
    localparam int unsigned ERR_W      = 31;
    localparam int unsigned SCORE_W    = 30;
    localparam int unsigned DCODE_OUT_W = 5;

    // Oscillator window, scaled by 65536.
    localparam logic [47:0] OSC_MIN_SCALED = 48'd22937600000000;
    localparam logic [47:0] OSC_MAX_SCALED = 48'd32768000000000;

    localparam logic [SCORE_W-1:0] NO_ERR_SCORE = 30'd999999999;
    localparam logic [ERR_W-1:0]   NO_ERR_VALUE = 31'd999999999;

    localparam logic [7:0] S1_LOW_MULT4  = 8'd192;
    localparam logic [7:0] S1_HIGH_MULT8 = 8'd128;
    localparam logic [7:0] BYTE_MAX      = 8'd255;

    localparam logic [3:0] MULT_FIRST = 4'd4;
    localparam logic [3:0] MULT_LAST  = 4'd8;

    // Register map (byte address bit 2 selects the register index).
    localparam logic REG_CRYSTAL_HZ = 1'b0;

    localparam logic [FREQ_W-1:0] CRYSTAL_RESET = 27'd40000000;

endpackage

/* hw/rtl/apss_if.sv */
// Valid/ready channel interfaces for target requests and search results.
interface apss_in_if;
    logic                             valid;
    logic                             ready;
    logic [apss_pkg::FREQ_W-1:0]      target_freq_hz;

    modport source (output valid, output target_freq_hz, input ready);
    modport sink   (input valid, input target_freq_hz, output ready);
endinterface

interface apss_out_if;
    logic                                valid;
    logic                                ready;
    logic                                found;
    logic [7:0]                          fraction_low;
    logic [7:0]                          fraction_high;
    logic [3:0]                          integer_mult;
    logic [apss_pkg::DCODE_OUT_W-1:0]    output_divider;
    logic [apss_pkg::ACH_W-1:0]          achieved_hz;
    logic signed [apss_pkg::ERR_W-1:0]   error_hz;

    modport source (output valid, output found, output fraction_low, output fraction_high,
                    output integer_mult, output output_divider, output achieved_hz,
                    output error_hz, input ready);
    modport sink   (input valid, input found, input fraction_low, input fraction_high,
                    input integer_mult, input output_divider, input achieved_hz,
                    input error_hz, output ready);
endinterface

/* hw/rtl/apss_div.sv */
// Shared restoring divider, one quotient bit per cycle, unsigned magnitudes.
module apss_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [apss_pkg::DIVIDEND_W-1:0]     i_dividend,
    input  logic [apss_pkg::DIVISOR_W-1:0]      i_divisor,
    output logic                                o_done,
    output logic [apss_pkg::DIVIDEND_W-1:0]     o_quotient,
    output logic [apss_pkg::DIVISOR_W-1:0]      o_remainder
);
    localparam int unsigned CNT_W = $clog2(apss_pkg::DIVIDEND_W);

    logic                                r_busy;
    logic                                r_done;
    logic [CNT_W-1:0]                    r_cnt;
    logic [apss_pkg::DIVIDEND_W-1:0]     r_quo;
    logic [apss_pkg::DIVISOR_W-1:0]      r_rem;
    logic [apss_pkg::DIVISOR_W-1:0]      r_dvs;
    logic [apss_pkg::DIVISOR_W:0]        trial;
    logic                                fits;

    assign trial = {r_rem, r_quo[apss_pkg::DIVIDEND_W-1]};
    assign fits  = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(apss_pkg::DIVIDEND_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[apss_pkg::DIVIDEND_W-2:0], fits};
            r_rem <= fits ? apss_pkg::DIVISOR_W'(trial - {1'b0, r_dvs})
                          : trial[apss_pkg::DIVISOR_W-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

/* hw/rtl/audio_pll_setting_search_top.sv */
// Top level of the audio PLL setting search: sequencer, configuration port, result register.
//
// The block takes one target frequency per transaction and searches every output divider
// code (0 to MAX_DIVIDER_CODE) against the integer multipliers 4 to 8 for the audio PLL
// setting whose output comes closest to the target, keeping the first strictly better
// candidate and stopping early on an exact match. Each candidate runs through up to three
// divisions on one shared restoring divider that yields one quotient bit per cycle, and a
// full search covers 160 candidates; an exact match ends it sooner, and a crystal setting
// of zero gives the "not found" result without running any candidate. The input is not
// ready while a search runs. The result sits in an output register until it is taken, so
// a new search can start while it waits. The crystal frequency is written through the
// APB port at byte address 0 and should only change while the block is idle.
module audio_pll_setting_search_top #(
    parameter int unsigned MAX_DIVIDER_CODE = 31
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    apss_in_if.sink             i_in,
    apss_out_if.source          o_out,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    localparam int unsigned DCODE_W = $clog2(MAX_DIVIDER_CODE + 1);
    localparam int unsigned DIV_W   = DCODE_W + 2;
    localparam int unsigned DVD_W   = apss_pkg::DIVIDEND_W;
    localparam int unsigned DVS_W   = apss_pkg::DIVISOR_W;
    localparam int unsigned F_W     = apss_pkg::FREQ_W;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL_FD, S_MUL_XK, S_DIFF, S_DIV_S1, S_MUL_XS1, S_SUB0,
        S_DIV_S0, S_MUL_OSC, S_CHECK, S_DIV_ERR, S_NEXT, S_OUT
    } t_state;

    t_state                      r_state;
    logic [F_W-1:0]              r_crystal;
    logic [F_W-1:0]              r_f;
    logic [F_W-1:0]              r_x;
    logic [DCODE_W-1:0]          r_d;
    logic [3:0]                  r_s2;
    logic [35:0]                 r_fd2;
    logic [30:0]                 r_xk;
    logic signed [37:0]          r_a;
    logic [7:0]                  r_s1;
    logic [7:0]                  r_s0;
    logic [47:0]                 r_t;
    logic                        r_num_zero;
    logic                        r_dsign;
    logic                        r_stop;
    logic                        r_found;
    logic [apss_pkg::SCORE_W-1:0] r_bscore;
    logic signed [apss_pkg::ERR_W-1:0] r_berr;
    logic [apss_pkg::ACH_W-1:0]  r_bach;
    logic [7:0]                  r_bs0;
    logic [7:0]                  r_bs1;
    logic [3:0]                  r_bs2;
    logic [DCODE_W-1:0]          r_bd;
    logic                        r_ovalid;

    logic                        div_start;
    logic [DVD_W-1:0]            div_dividend;
    logic [DVS_W-1:0]            div_divisor;
    logic                        div_done;
    logic [DVD_W-1:0]            div_quo;
    logic [DVS_W-1:0]            div_rem;

    logic [DIV_W-1:0]            divisor_d;
    logic [3:0]                  mult_k;
    logic signed [37:0]          a_val;
    logic signed [DVD_W-1:0]     launch_val;
    logic                        q_neg;
    logic [7:0]                  s1_lo;
    logic [7:0]                  s1_hi;
    logic [7:0]                  s1_clamped;
    logic [7:0]                  s0_clamped;
    logic signed [apss_pkg::ERR_W-1:0] err_val;
    logic                        ach_adj;
    logic signed [31:0]          ach_val;
    logic                        osc_ok;
    logic                        last_pair;
    logic                        cfg_write;

    assign divisor_d = DIV_W'({r_d, 1'b0}) + DIV_W'(4);
    assign mult_k    = r_s2 + 4'd4;
    assign a_val     = $signed({2'b0, r_fd2}) - $signed({7'b0, r_xk});
    assign q_neg     = r_dsign && (div_quo != '0);
    assign s1_lo     = (r_s2 == apss_pkg::MULT_FIRST) ? apss_pkg::S1_LOW_MULT4 : 8'd0;
    assign s1_hi     = (r_s2 == apss_pkg::MULT_LAST) ? apss_pkg::S1_HIGH_MULT8
                                                      : apss_pkg::BYTE_MAX;
    assign osc_ok    = (r_t >= apss_pkg::OSC_MIN_SCALED) && (r_t <= apss_pkg::OSC_MAX_SCALED);
    assign last_pair = (r_d == DCODE_W'(MAX_DIVIDER_CODE)) && (r_s2 == apss_pkg::MULT_LAST);

    // Signed truncating quotients are clamped from the magnitude and the sign.
    always_comb begin
        if (q_neg) begin
            s1_clamped = s1_lo;
        end else if (div_quo > DVD_W'(s1_hi)) begin
            s1_clamped = s1_hi;
        end else if (div_quo < DVD_W'(s1_lo)) begin
            s1_clamped = s1_lo;
        end else begin
            s1_clamped = div_quo[7:0];
        end
        if (q_neg) begin
            s0_clamped = 8'd0;
        end else if (div_quo > DVD_W'(apss_pkg::BYTE_MAX)) begin
            s0_clamped = apss_pkg::BYTE_MAX;
        end else begin
            s0_clamped = div_quo[7:0];
        end
    end

    // The achieved frequency follows from the error quotient and remainder: for a positive
    // numerator with a nonzero remainder the floor lies one below target minus error.
    assign err_val = r_dsign ? -$signed(div_quo[apss_pkg::ERR_W-1:0])
                             : $signed(div_quo[apss_pkg::ERR_W-1:0]);
    assign ach_adj = !r_dsign && !r_num_zero && (div_rem != '0);
    assign ach_val = $signed({5'b0, r_f}) - 32'(err_val) - $signed({31'b0, ach_adj});

    // Signed value handed to the divider as sign and magnitude.
    always_comb begin
        launch_val  = '0;
        div_divisor = r_x;
        div_start   = 1'b0;
        case (r_state)
            S_DIFF: begin
                launch_val = DVD_W'(a_val) <<< 8;
                div_start  = 1'b1;
            end
            S_SUB0: begin
                launch_val = ((DVD_W'(r_a) <<< 8) - $signed({21'b0, r_t[34:0]})) <<< 8;
                div_start  = 1'b1;
            end
            S_CHECK: begin
                launch_val  = $signed({4'b0, r_fd2, 16'b0}) - $signed({8'b0, r_t});
                div_divisor = DVS_W'({divisor_d, 17'b0});
                div_start   = osc_ok;
            end
            default: begin
                launch_val = '0;
            end
        endcase
    end

    assign div_dividend = launch_val[DVD_W-1] ? DVD_W'(-launch_val) : DVD_W'(launch_val);

    apss_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            // A new result may replace the one that is taken at this same edge.
            if ((r_state == S_OUT) && (!r_ovalid || o_out.ready)) begin
                r_ovalid <= 1'b1;
            end else if (o_out.valid && o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_f        <= i_in.target_freq_hz;
                        r_x        <= r_crystal;
                        r_d        <= '0;
                        r_s2       <= apss_pkg::MULT_FIRST;
                        r_stop     <= 1'b0;
                        r_found    <= 1'b0;
                        r_bscore   <= apss_pkg::NO_ERR_SCORE;
                        r_berr     <= apss_pkg::NO_ERR_VALUE;
                        r_bach     <= '0;
                        r_bs0      <= '0;
                        r_bs1      <= '0;
                        r_bs2      <= '0;
                        r_bd       <= '0;
                        r_state    <= (r_crystal == '0) ? S_OUT : S_MUL_FD;
                    end
                end
                S_MUL_FD: begin
                    r_fd2   <= (36'(r_f) * 36'(divisor_d)) << 1;
                    r_state <= S_MUL_XK;
                end
                S_MUL_XK: begin
                    r_xk    <= 31'(r_x) * 31'(mult_k);
                    r_state <= S_DIFF;
                end
                S_DIFF: begin
                    r_a     <= a_val;
                    r_dsign <= launch_val[DVD_W-1];
                    r_state <= S_DIV_S1;
                end
                S_DIV_S1: begin
                    if (div_done) begin
                        r_s1 <= s1_clamped;
                        if ((r_s2 == apss_pkg::MULT_LAST)
                            && (s1_clamped == apss_pkg::S1_HIGH_MULT8)) begin
                            r_s0    <= 8'd0;
                            r_state <= S_MUL_OSC;
                        end else begin
                            r_state <= S_MUL_XS1;
                        end
                    end
                end
                S_MUL_XS1: begin
                    r_t     <= 48'(r_x) * 48'(r_s1);
                    r_state <= S_SUB0;
                end
                S_SUB0: begin
                    r_dsign <= launch_val[DVD_W-1];
                    r_state <= S_DIV_S0;
                end
                S_DIV_S0: begin
                    if (div_done) begin
                        r_s0    <= s0_clamped;
                        r_state <= S_MUL_OSC;
                    end
                end
                S_MUL_OSC: begin
                    r_t     <= 48'(r_x) * 48'({mult_k, r_s1, r_s0});
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    r_dsign    <= launch_val[DVD_W-1];
                    r_num_zero <= (launch_val == '0);
                    r_state    <= osc_ok ? S_DIV_ERR : S_NEXT;
                end
                S_DIV_ERR: begin
                    if (div_done) begin
                        if (div_quo[apss_pkg::SCORE_W-1:0] < r_bscore) begin
                            r_found  <= 1'b1;
                            r_bscore <= div_quo[apss_pkg::SCORE_W-1:0];
                            r_berr   <= err_val;
                            r_bach   <= ach_val[apss_pkg::ACH_W-1:0];
                            r_bs0    <= r_s0;
                            r_bs1    <= r_s1;
                            r_bs2    <= r_s2;
                            r_bd     <= r_d;
                            r_stop   <= r_num_zero;
                        end
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (r_stop || last_pair) begin
                        r_state <= S_OUT;
                    end else begin
                        if (r_s2 == apss_pkg::MULT_LAST) begin
                            r_s2 <= apss_pkg::MULT_FIRST;
                            r_d  <= r_d + 1'b1;
                        end else begin
                            r_s2 <= r_s2 + 1'b1;
                        end
                        r_state <= S_MUL_FD;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || o_out.ready) begin
                        o_out.found            <= r_found;
                        o_out.fraction_low     <= r_bs0;
                        o_out.fraction_high    <= r_bs1;
                        o_out.integer_mult     <= r_bs2;
                        o_out.output_divider   <= apss_pkg::DCODE_OUT_W'(r_bd);
                        o_out.achieved_hz      <= r_bach;
                        o_out.error_hz         <= r_berr;
                        r_state                <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_ovalid;

    // Configuration register.
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crystal <= apss_pkg::CRYSTAL_RESET;
        end else if (cfg_write && (paddr[2] == apss_pkg::REG_CRYSTAL_HZ)) begin
            r_crystal <= pwdata[F_W-1:0];
        end
    end

    assign prdata = (paddr[2] == apss_pkg::REG_CRYSTAL_HZ) ? {5'b0, r_crystal} : 32'd0;
    assign pready = 1'b1;

    // A new search always leaves the idle state on the next edge.
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state != S_IDLE))
        else $error("search did not start after an accepted transaction");

    // A kept candidate always carries a multiplier in the searched range.
    a_found_mult_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_found && r_state != S_IDLE) |-> (r_bs2 >= apss_pkg::MULT_FIRST
                                            && r_bs2 <= apss_pkg::MULT_LAST))
        else $error("kept candidate has an out-of-range multiplier");

    // The divider only reports completion while the sequencer waits for it.
    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV_S1 || r_state == S_DIV_S0 || r_state == S_DIV_ERR))
        else $error("divider finished outside a wait state");

    // The best score never grows within one search.
    a_score_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && $past(r_state) != S_IDLE) |-> (r_bscore <= $past(r_bscore)))
        else $error("best score increased during a search");

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the audio PLL setting search, with a driver, a monitor and APB writes.
module testbench;

    typedef enum logic [2:0] {
        STEP_TARGET,   // offer one target frequency
        STEP_CRYSTAL,  // write the crystal register once the block is idle
        STEP_DRAIN,    // stop sending until every expected result is back
        STEP_PHASE,    // change the idle rates of both sides
        STEP_HOLD      // make the receiver hold off for a long stretch
    } t_step_kind;

    typedef struct {
        t_step_kind  kind;
        logic [31:0] value;
        int          aux;
    } t_plan_step;

    typedef struct {
        logic                              found;
        logic [7:0]                        fraction_low;
        logic [7:0]                        fraction_high;
        logic [3:0]                        integer_mult;
        logic [apss_pkg::DCODE_OUT_W-1:0]  output_divider;
        logic [apss_pkg::ACH_W-1:0]        achieved_hz;
        logic signed [apss_pkg::ERR_W-1:0] error_hz;
    } t_pll_setting;

    localparam int DIVIDER_CODES = 31;
    localparam int SETTLE_CYCLES = 16;
    localparam int LONG_HOLD     = 80000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    apss_in_if  req_if ();
    apss_out_if res_if ();

    initial begin
        req_if.valid = 1'b0;
        req_if.target_freq_hz = '0;
        res_if.ready = 1'b0;
    end

    audio_pll_setting_search_top #(.MAX_DIVIDER_CODE(DIVIDER_CODES)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if.sink),
        .o_out   (res_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // The clock runs with a period of 20 time units.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    t_plan_step   stimulus_plan[$];
    t_pll_setting pending_settings[$];
    logic [26:0]  crystal_now = apss_pkg::CRYSTAL_RESET;   // crystal as the block holds it
    int           mismatches = 0;
    int           send_gap = 6;                  // percent of cycles the sender idles
    int           recv_gap = 60;                 // percent of cycles the receiver idles
    int           hold_len = 0;
    int           hold_token = 0;
    int           hold_seen = 0;
    int           hold_left = 0;
    int           apb_state = 0;
    int           idle_cycles = 0;

    // Search over all divider codes and integer multipliers, stopping on an exact match,
    // in exact integer arithmetic. Longint division truncates toward zero, as needed.
    function automatic t_pll_setting search_setting(logic [26:0] tgt, logic [26:0] xtal);
        t_pll_setting r;
        longint f, x, div, a, s1, s0, lo1, hi1, m, osc, den, num, err, score, best, ach;
        bit done;
        f = tgt;
        x = xtal;
        best = 999999999;
        done = 0;
        r.found = 1'b0;
        r.fraction_low = '0;
        r.fraction_high = '0;
        r.integer_mult = '0;
        r.output_divider = '0;
        r.achieved_hz = '0;
        r.error_hz = apss_pkg::NO_ERR_VALUE;
        if (x != 0) begin
            for (int d = 0; d <= DIVIDER_CODES && !done; d++) begin
                div = 2 * d + 4;
                for (int s2 = apss_pkg::MULT_FIRST; s2 <= apss_pkg::MULT_LAST && !done;
                     s2++) begin
                    lo1 = (s2 == apss_pkg::MULT_FIRST) ? longint'(apss_pkg::S1_LOW_MULT4) : 0;
                    hi1 = (s2 == apss_pkg::MULT_LAST) ? longint'(apss_pkg::S1_HIGH_MULT8)
                                                      : longint'(apss_pkg::BYTE_MAX);
                    a = 2 * f * div - x * (4 + s2);
                    s1 = (a * 256) / x;
                    if (s1 < lo1) s1 = lo1;
                    if (s1 > hi1) s1 = hi1;
                    if (s2 == apss_pkg::MULT_LAST
                        && s1 == longint'(apss_pkg::S1_HIGH_MULT8)) begin
                        s0 = 0;
                    end else begin
                        s0 = ((a * 256 - x * s1) * 256) / x;
                        if (s0 < 0) s0 = 0;
                        if (s0 > 255) s0 = 255;
                    end
                    m = 65536 * (4 + s2) + 256 * s1 + s0;
                    osc = x * m;
                    if (osc < longint'(apss_pkg::OSC_MIN_SCALED)
                        || osc > longint'(apss_pkg::OSC_MAX_SCALED))
                        continue;
                    den = 131072 * div;
                    num = f * den - osc;
                    err = num / den;
                    score = (err < 0) ? -err : err;
                    if (score < best) begin
                        best = score;
                        ach = osc / den;
                        r.found = 1'b1;
                        r.fraction_low = s0[7:0];
                        r.fraction_high = s1[7:0];
                        r.integer_mult = s2[3:0];
                        r.output_divider = d[apss_pkg::DCODE_OUT_W-1:0];
                        r.achieved_hz = ach[apss_pkg::ACH_W-1:0];
                        r.error_hz = err[apss_pkg::ERR_W-1:0];
                        if (num == 0) done = 1;
                    end
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Driver: walks the plan one step at a time. Target frequencies are
    // offered on the request channel; crystal writes wait until the block
    // has returned every result and the idle counter has reached SETTLE_CYCLES.
    always @(posedge i_clk) begin
        bit offering;
        t_plan_step head;
        offering = req_if.valid;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            psel <= 1'b0;
            penable <= 1'b0;
            pwrite <= 1'b0;
        end else begin
            idle_cycles <= (pending_settings.size() == 0 && !req_if.valid) ? idle_cycles + 1 : 0;
            if (req_if.valid && req_if.ready) begin
                pending_settings.push_back(search_setting(req_if.target_freq_hz, crystal_now));
                offering = 0;
            end
            if (apb_state == 1) begin
                penable <= 1'b1;
                apb_state = 2;
            end else if (apb_state == 2) begin
                // The register took the value at this edge.
                crystal_now = pwdata[26:0];
                psel <= 1'b0;
                penable <= 1'b0;
                pwrite <= 1'b0;
                apb_state = 0;
            end else if (!offering && stimulus_plan.size() > 0) begin
                head = stimulus_plan[0];
                case (head.kind)
                    STEP_TARGET: begin
                        if ($urandom_range(99) >= send_gap) begin
                            req_if.valid <= 1'b1;
                            req_if.target_freq_hz <= head.value[26:0];
                            offering = 1;
                            void'(stimulus_plan.pop_front());
                        end
                    end
                    STEP_CRYSTAL: begin
                        if (idle_cycles >= SETTLE_CYCLES && pending_settings.size() == 0) begin
                            psel <= 1'b1;
                            pwrite <= 1'b1;
                            paddr <= {apss_pkg::REG_CRYSTAL_HZ, 2'b00};
                            pwdata <= head.value;
                            apb_state = 1;
                            void'(stimulus_plan.pop_front());
                        end
                    end
                    STEP_DRAIN: begin
                        if (pending_settings.size() == 0) void'(stimulus_plan.pop_front());
                    end
                    STEP_PHASE: begin
                        send_gap = head.value;
                        recv_gap = head.aux;
                        void'(stimulus_plan.pop_front());
                    end
                    STEP_HOLD: begin
                        hold_len <= head.value;
                        hold_token <= hold_token + 1;
                        void'(stimulus_plan.pop_front());
                    end
                    default: begin
                        void'(stimulus_plan.pop_front());
                    end
                endcase
            end
            if (!offering) req_if.valid <= 1'b0;
        end
    end

    // Monitor: checks each result transaction against the oldest expected
    // setting and drives the receiver's ready, including the long hold-off.
    always @(posedge i_clk) begin
        t_pll_setting want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (pending_settings.size() == 0) begin
                    report_mismatch("unexpected result, found", res_if.found, 0);
                end else begin
                    want = pending_settings.pop_front();
                    if (res_if.found !== want.found)
                        report_mismatch("found", res_if.found, want.found);
                    if (res_if.fraction_low !== want.fraction_low)
                        report_mismatch("fraction_low", res_if.fraction_low, want.fraction_low);
                    if (res_if.fraction_high !== want.fraction_high)
                        report_mismatch("fraction_high", res_if.fraction_high,
                                        want.fraction_high);
                    if (res_if.integer_mult !== want.integer_mult)
                        report_mismatch("integer_mult", res_if.integer_mult, want.integer_mult);
                    if (res_if.output_divider !== want.output_divider)
                        report_mismatch("output_divider", res_if.output_divider,
                                        want.output_divider);
                    if (res_if.achieved_hz !== want.achieved_hz)
                        report_mismatch("achieved_hz", res_if.achieved_hz, want.achieved_hz);
                    if (res_if.error_hz !== want.error_hz)
                        report_mismatch("error_hz", res_if.error_hz, want.error_hz);
                end
            end
            if (hold_token != hold_seen) begin
                hold_seen <= hold_token;
                hold_left <= hold_len;
                res_if.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(99) >= recv_gap);
            end
        end
    end

    task automatic plan_target(logic [26:0] tgt);
        stimulus_plan.push_back('{STEP_TARGET, {5'd0, tgt}, 0});
    endtask

    task automatic plan_step(t_step_kind kind, logic [31:0] value, int aux);
        stimulus_plan.push_back('{kind, value, aux});
    endtask

    // Random targets lean toward audio clock rates, with some spread over
    // the whole 27-bit range and some very low values.
    function automatic logic [26:0] random_target();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70) return 27'($urandom_range(50000000, 1000000));
        if (pick < 85) return 27'($urandom());
        return 27'($urandom_range(100000));
    endfunction

    initial begin
        t_pll_setting near;
        // Directed part at the reset crystal: field extremes, common audio
        // clocks, and two targets equal to frequencies that the search itself
        // reports as achieved.
        plan_target(27'd0);
        plan_target(27'h7FFFFFF);
        plan_target(27'd1);
        plan_target(27'd12288000);
        plan_target(27'd11289600);
        plan_target(27'd24576000);
        near = search_setting(27'd12288000, apss_pkg::CRYSTAL_RESET);
        plan_target(27'(near.achieved_hz));
        near = search_setting(27'd2822400, apss_pkg::CRYSTAL_RESET);
        plan_target(27'(near.achieved_hz));
        // Crystal at the top of its band, then at the bottom, where nothing
        // can reach the oscillator window.
        plan_step(STEP_CRYSTAL, 32'd80000000, 0);
        plan_target(27'd12288000);
        plan_target(27'd62500000);
        near = search_setting(27'd6144000, 27'd80000000);
        plan_target(27'(near.achieved_hz));
        plan_step(STEP_CRYSTAL, 32'd1000000, 0);
        plan_target(27'd12288000);
        plan_target(27'd0);
        // A zero crystal gives the not-found result at once.
        plan_step(STEP_CRYSTAL, 32'd0, 0);
        plan_target(27'd12288000);
        plan_target(27'h7FFFFFF);
        plan_step(STEP_CRYSTAL, 32'h07FFFFFF, 0);
        plan_target(27'd24576000);
        plan_target(27'd1000000);

        // Random part in three phases of idling, each with a fresh crystal.
        for (int ph = 0; ph < 3; ph++) begin
            plan_step(STEP_DRAIN, 0, 0);
            plan_step(STEP_PHASE, (ph == 0) ? 6 : (ph == 1) ? 60 : 0,
                      (ph == 0) ? 60 : (ph == 1) ? 6 : 0);
            plan_step(STEP_CRYSTAL, $urandom_range(80000000, 1000000), 0);
            if (ph == 2) plan_step(STEP_HOLD, LONG_HOLD, 0);
            for (int k = 0; k < 34; k++) begin
                plan_target(random_target());
                if (k == 17) plan_step(STEP_DRAIN, 0, 0);
            end
        end
        // Back to the reset value so the last phase ends at a known crystal.
        plan_step(STEP_DRAIN, 0, 0);
        plan_step(STEP_CRYSTAL, 32'(apss_pkg::CRYSTAL_RESET), 0);
        plan_target(27'd11289600);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (stimulus_plan.size() != 0 || req_if.valid || pending_settings.size() != 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // This time limit allows for several times the whole plan plus the long
    // hold-off.
    initial begin
        #(20 * 20000000);
        $display("Mismatches found");
        $finish;
    end

endmodule
